### rtl/shuffled_id_allocator_top_assert.svh
// Assertion macros shared by the shuffled ID allocator RTL.
`ifndef SHUFFLED_ID_ALLOCATOR_TOP_ASSERT_SVH
`define SHUFFLED_ID_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define SIA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define SIA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sia_pkg.sv
// Types, codes and helper functions of the shuffled ID allocator.
package sia_pkg;

    localparam int ID_W   = 10;
    localparam int REQ_W  = 2;
    localparam int ST_W   = 2;
    localparam int LFSR_W = 16;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [REQ_W-1:0] REQ_INIT    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_EXHAUSTED  = 2'd1;
    localparam logic [ST_W-1:0] ST_STACK_FULL = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_INIT   = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [ID_W-1:0]  release_id;
    } sia_req_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [ST_W-1:0] status;
    } sia_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_WAIT,
        S_FILL,
        S_STEP,
        S_DIV,
        S_SWAP_RD,
        S_WR_I,
        S_WR_J
    } sia_state_t;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0])
        begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

### rtl/sia_pool_ram.sv
// Pool memory: one write port, two registered read ports.
module sia_pool_ram import sia_pkg::*; #(
    parameter int DEPTH = 900,
    parameter int AW    = 10
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  logic [ID_W-1:0] wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr_a,
    input  logic [AW-1:0]   raddr_b,
    output logic [ID_W-1:0] rdata_a,
    output logic [ID_W-1:0] rdata_b
);

    logic [ID_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### rtl/sia_stack_ram.sv
// Free stack memory: one write port, one registered read port.
module sia_stack_ram import sia_pkg::*; #(
    parameter int DEPTH = 900,
    parameter int AW    = 10
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  logic [ID_W-1:0] wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output logic [ID_W-1:0] rdata
);

    logic [ID_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/sia_mod_unit.sv
// Bit-serial remainder unit: LFSR value modulo a shuffle bound.
`include "shuffled_id_allocator_top_assert.svh"
module sia_mod_unit import sia_pkg::*; #(
    parameter int DW = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [LFSR_W-1:0] dividend,
    input  logic [DW-1:0]     divisor,
    output logic              done,
    output logic [DW-1:0]     rem
);

    localparam int CNT_W = $clog2(LFSR_W);

    logic              run_reg,  run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [DW-1:0]     rem_reg,  rem_next;
    logic [DW-1:0]     div_reg,  div_next;
    logic [LFSR_W-1:0] dvd_reg,  dvd_next;
    logic [DW:0]       trial;
    logic [DW-1:0]     rem_step;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[LFSR_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_step = DW'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_step = trial[DW-1:0];
        end
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        dvd_next  = dvd_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            div_next = divisor;
            dvd_next = dividend;
        end
        else if (run_reg)
        begin
            rem_next = rem_step;
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(LFSR_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        dvd_reg <= dvd_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    `SIA_ASSERT_IMP(a_no_restart, start, !run_reg, "mod unit restarted while running")
    `SIA_ASSERT_NXT(a_done_pulse, done_reg, !done_reg, "mod unit done held twice")
    `SIA_ASSERT_IMP(a_rem_bound, done_reg, rem_reg < div_reg, "remainder not below divisor")

endmodule

### rtl/shuffled_id_allocator_top.sv
// Top level of the shuffled ID allocator: request sequencer and memories.
// A request is taken when start is high and busy is low. Release, unused and
// failed allocate requests answer in the next cycle and the next request may
// follow at once; a successful allocate answers through the registered memory
// read and the response register and holds busy for one cycle. Init fills the
// pool and then shuffles it. Each swap steps the LFSR and starts the bit-serial
// remainder unit, waits while it runs, then does one read and two writes on
// the single pool write port; after POOL_SIZE-1 swaps it answers.
// Every result appears for exactly one cycle with done high and must be
// captured then; the receiver has no way to hold it.
`include "shuffled_id_allocator_top_assert.svh"
module shuffled_id_allocator_top import sia_pkg::*; #(
    parameter int ID_BASE   = 100,
    parameter int POOL_SIZE = 900
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sia_req_t          req,
    output logic              done,
    output sia_rsp_t          rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LFSR_W-1:0] cfg_data
);

    localparam int IW = $clog2(POOL_SIZE);
    localparam int CW = $clog2(POOL_SIZE + 1);

    sia_state_t        state_reg, state_next;
    logic [LFSR_W-1:0] seed_reg, seed_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next_val;
    logic              ready_reg, ready_next;
    logic [CW-1:0]     free_cnt_reg, free_cnt_next;
    logic [CW-1:0]     next_idx_reg, next_idx_next;
    logic [IW-1:0]     fill_idx_reg, fill_idx_next;
    logic [IW-1:0]     shuf_i_reg, shuf_i_next;
    logic [IW-1:0]     j_reg, j_next;
    logic              src_stack_reg, src_stack_next;
    logic              done_reg, done_next;
    sia_rsp_t          rsp_reg, rsp_next;

    logic              acc;
    logic [LFSR_W-1:0] lfsr_stepped;
    logic [CW-1:0]     free_cnt_dec;

    logic              pool_we, pool_re;
    logic [IW-1:0]     pool_waddr, pool_raddr_a, pool_raddr_b;
    logic [ID_W-1:0]   pool_wdata, pool_rdata_a, pool_rdata_b;
    logic              stack_we, stack_re;
    logic [IW-1:0]     stack_waddr, stack_raddr;
    logic [ID_W-1:0]   stack_rdata;
    logic              mod_start, mod_done;
    logic [CW-1:0]     mod_rem;

    assign acc          = start && (state_reg == S_IDLE);
    assign lfsr_stepped = lfsr_next(lfsr_reg);
    assign free_cnt_dec = free_cnt_reg - 1'b1;
    assign cfg_ready    = 1'b1;

    sia_pool_ram #(.DEPTH(POOL_SIZE), .AW(IW)) u_pool (
        .clk     (clk),
        .we      (pool_we),
        .waddr   (pool_waddr),
        .wdata   (pool_wdata),
        .re      (pool_re),
        .raddr_a (pool_raddr_a),
        .raddr_b (pool_raddr_b),
        .rdata_a (pool_rdata_a),
        .rdata_b (pool_rdata_b)
    );

    sia_stack_ram #(.DEPTH(POOL_SIZE), .AW(IW)) u_stack (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (req.release_id),
        .re    (stack_re),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    sia_mod_unit #(.DW(CW)) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (lfsr_stepped),
        .divisor  (CW'(shuf_i_reg) + 1'b1),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (req.req_type)
                        REQ_INIT:
                        begin
                            state_next = S_FILL;
                        end
                        REQ_ALLOC:
                        begin
                            if (ready_reg && (free_cnt_reg != '0 ||
                                              next_idx_reg < CW'(POOL_SIZE)))
                            begin
                                state_next = S_ALLOC_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ALLOC_WAIT:
            begin
                state_next = S_IDLE;
            end
            S_FILL:
            begin
                if (fill_idx_reg == IW'(POOL_SIZE - 1))
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (mod_done)
                begin
                    state_next = S_SWAP_RD;
                end
            end
            S_SWAP_RD:
            begin
                state_next = S_WR_I;
            end
            S_WR_I:
            begin
                state_next = S_WR_J;
            end
            S_WR_J:
            begin
                state_next = (shuf_i_reg == IW'(1)) ? S_IDLE : S_STEP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory and unit controls
    always_comb
    begin
        busy         = (state_reg != S_IDLE);
        pool_we      = 1'b0;
        pool_waddr   = fill_idx_reg;
        pool_wdata   = ID_W'(ID_BASE) + ID_W'(fill_idx_reg);
        pool_re      = 1'b0;
        pool_raddr_a = next_idx_reg[IW-1:0];
        pool_raddr_b = j_reg;
        stack_we     = 1'b0;
        stack_waddr  = free_cnt_reg[IW-1:0];
        stack_re     = 1'b0;
        stack_raddr  = free_cnt_dec[IW-1:0];
        mod_start    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (acc && req.req_type == REQ_ALLOC && ready_reg)
                begin
                    if (free_cnt_reg != '0)
                    begin
                        stack_re = 1'b1;
                    end
                    else if (next_idx_reg < CW'(POOL_SIZE))
                    begin
                        pool_re = 1'b1;
                    end
                end
                if (acc && req.req_type == REQ_RELEASE && free_cnt_reg < CW'(POOL_SIZE))
                begin
                    stack_we = 1'b1;
                end
            end
            S_FILL:
            begin
                pool_we = 1'b1;
            end
            S_STEP:
            begin
                mod_start = 1'b1;
            end
            S_SWAP_RD:
            begin
                pool_re      = 1'b1;
                pool_raddr_a = shuf_i_reg;
            end
            S_WR_I:
            begin
                pool_we    = 1'b1;
                pool_waddr = shuf_i_reg;
                pool_wdata = pool_rdata_b;
            end
            S_WR_J:
            begin
                pool_we    = 1'b1;
                pool_waddr = j_reg;
                pool_wdata = pool_rdata_a;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        seed_next      = (cfg_valid && cfg_ready) ? cfg_data : seed_reg;
        lfsr_next_val  = lfsr_reg;
        ready_next     = ready_reg;
        free_cnt_next  = free_cnt_reg;
        next_idx_next  = next_idx_reg;
        fill_idx_next  = fill_idx_reg;
        shuf_i_next    = shuf_i_reg;
        j_next         = j_reg;
        src_stack_next = src_stack_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    done_next       = 1'b1;
                    rsp_next.id     = '0;
                    rsp_next.status = ST_OK;
                    case (req.req_type)
                        REQ_INIT:
                        begin
                            done_next     = 1'b0;
                            free_cnt_next = '0;
                            next_idx_next = '0;
                            fill_idx_next = '0;
                            lfsr_next_val = (seed_reg != '0) ? seed_reg : LFSR_W'(1);
                        end
                        REQ_ALLOC:
                        begin
                            if (!ready_reg)
                            begin
                                rsp_next.status = ST_NOT_INIT;
                            end
                            else if (free_cnt_reg != '0)
                            begin
                                done_next      = 1'b0;
                                src_stack_next = 1'b1;
                                free_cnt_next  = free_cnt_reg - 1'b1;
                            end
                            else if (next_idx_reg < CW'(POOL_SIZE))
                            begin
                                done_next      = 1'b0;
                                src_stack_next = 1'b0;
                                next_idx_next  = next_idx_reg + 1'b1;
                            end
                            else
                            begin
                                rsp_next.status = ST_EXHAUSTED;
                            end
                        end
                        REQ_RELEASE:
                        begin
                            if (free_cnt_reg < CW'(POOL_SIZE))
                            begin
                                free_cnt_next = free_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                rsp_next.status = ST_STACK_FULL;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = ST_OK;
                        end
                    endcase
                end
            end
            S_ALLOC_WAIT:
            begin
                done_next       = 1'b1;
                rsp_next.id     = src_stack_reg ? stack_rdata : pool_rdata_a;
                rsp_next.status = ST_OK;
            end
            S_FILL:
            begin
                fill_idx_next = fill_idx_reg + 1'b1;
                shuf_i_next   = IW'(POOL_SIZE - 1);
            end
            S_STEP:
            begin
                lfsr_next_val = lfsr_stepped;
            end
            S_DIV:
            begin
                j_next = mod_rem[IW-1:0];
            end
            S_WR_J:
            begin
                if (shuf_i_reg == IW'(1))
                begin
                    ready_next      = 1'b1;
                    done_next       = 1'b1;
                    rsp_next.id     = '0;
                    rsp_next.status = ST_OK;
                end
                else
                begin
                    shuf_i_next = shuf_i_reg - 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            seed_reg     <= LFSR_W'(1);
            lfsr_reg     <= LFSR_W'(1);
            ready_reg    <= 1'b0;
            free_cnt_reg <= '0;
            next_idx_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            seed_reg     <= seed_next;
            lfsr_reg     <= lfsr_next_val;
            ready_reg    <= ready_next;
            free_cnt_reg <= free_cnt_next;
            next_idx_reg <= next_idx_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_idx_reg  <= fill_idx_next;
        shuf_i_reg    <= shuf_i_next;
        j_reg         <= j_next;
        src_stack_reg <= src_stack_next;
        rsp_reg       <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `SIA_ASSERT_IMP(a_done_idle, done_reg, state_reg == S_IDLE, "result shown while busy")
    `SIA_ASSERT_IMP(a_cnt_bound, 1'b1, free_cnt_reg <= CW'(POOL_SIZE), "free count overflow")
    `SIA_ASSERT_NXT(a_not_init, acc && req.req_type == REQ_ALLOC && !ready_reg,
                    done_reg && rsp_reg.status == ST_NOT_INIT, "allocate before init")
    `SIA_ASSERT_NXT(a_alloc_wait, state_reg == S_ALLOC_WAIT, done_reg, "allocate lost")

endmodule

### verif/testbench.sv
// Self-checking testbench of shuffled_id_allocator_top with a predicting scoreboard.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sia_pkg::*;

    localparam int ID_BASE    = 100;
    localparam int POOL_SIZE  = 900;
    localparam int CLK_PERIOD = 10;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int TAIL_CYCLES = 50;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    class alloc_scoreboard;
        logic [ID_W-1:0]   pool [POOL_SIZE];
        logic [ID_W-1:0]   free_ids [POOL_SIZE];
        int unsigned       free_count = 0;
        int unsigned       next_index = 0;
        logic [LFSR_W-1:0] seed = 16'd1;
        logic [LFSR_W-1:0] lfsr = 16'd1;
        bit                pool_ready = 1'b0;
        sia_rsp_t          expected_rsp [$];
        int                errors = 0;

        function void set_seed(input logic [LFSR_W-1:0] v);
            seed = v;
        endfunction

        function logic [LFSR_W-1:0] advance(input logic [LFSR_W-1:0] v);
            logic [LFSR_W-1:0] taps;
            taps = v[0] ? LFSR_TAPS : '0;
            return {1'b0, v[LFSR_W-1:1]} ^ taps;
        endfunction

        function void build_pool();
            int unsigned     j;
            logic [ID_W-1:0] tmp;
            free_count = 0;
            next_index = 0;
            lfsr = (seed != '0) ? seed : 16'd1;
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                pool[i] = ID_W'(ID_BASE + i);
            end
            for (int i = POOL_SIZE - 1; i > 0; i--)
            begin
                lfsr = advance(lfsr);
                j = int'(lfsr) % (i + 1);
                tmp = pool[i];
                pool[i] = pool[j];
                pool[j] = tmp;
            end
            pool_ready = 1'b1;
        endfunction

        function sia_rsp_t note_request(input sia_req_t r);
            sia_rsp_t e;
            e.id = '0;
            e.status = ST_OK;
            case (r.req_type)
                REQ_INIT:
                begin
                    build_pool();
                end
                REQ_ALLOC:
                begin
                    if (!pool_ready)
                    begin
                        e.status = ST_NOT_INIT;
                    end
                    else if (free_count > 0)
                    begin
                        free_count--;
                        e.id = free_ids[free_count];
                    end
                    else if (next_index < POOL_SIZE)
                    begin
                        e.id = pool[next_index];
                        next_index++;
                    end
                    else
                    begin
                        e.status = ST_EXHAUSTED;
                    end
                end
                REQ_RELEASE:
                begin
                    if (free_count < POOL_SIZE)
                    begin
                        free_ids[free_count] = r.release_id;
                        free_count++;
                    end
                    else
                    begin
                        e.status = ST_STACK_FULL;
                    end
                end
                default:
                begin
                end
            endcase
            expected_rsp.push_back(e);
            return e;
        endfunction

        function void check_result(input sia_rsp_t got);
            sia_rsp_t e;
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected result: id %0d status %0d", got.id, got.status);
                errors++;
                return;
            end
            e = expected_rsp.pop_front();
            if (got.id !== e.id)
            begin
                $error("id: expected %0d, actual %0d", e.id, got.id);
                errors++;
            end
            if (got.status !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, got.status);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_rsp.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    sia_req_t          req = '0;
    logic              done;
    sia_rsp_t          rsp;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LFSR_W-1:0] cfg_data = '0;

    alloc_scoreboard   sb = new();
    logic [ID_W-1:0]   held_ids [$];
    int                gap_pct = 0;
    int                inits_left = 4;
    int unsigned       cycle_count = 0;

    shuffled_id_allocator_top #(
        .ID_BASE   (ID_BASE),
        .POOL_SIZE (POOL_SIZE)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(rsp);
        end
    end

    task automatic issue(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] rid);
        sia_req_t r;
        sia_rsp_t e;
        r.req_type = kind;
        r.release_id = rid;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        do @(posedge clk); while (busy);
        e = sb.note_request(r);
        if (kind == REQ_INIT)
        begin
            held_ids.delete();
        end
        else if (kind == REQ_ALLOC && e.status == ST_OK)
        begin
            held_ids.push_back(e.id);
        end
    endtask

    // hold off new transactions until every response is back
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
    endtask

    task automatic write_seed(input logic [LFSR_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_seed(v);
    endtask

    task automatic release_held();
        int              k;
        logic [ID_W-1:0] rid;
        k = $urandom_range(held_ids.size() - 1);
        rid = held_ids[k];
        held_ids.delete(k);
        issue(REQ_RELEASE, rid);
    endtask

    task automatic random_items(input int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 2)
            begin
                settle();
            end
            pick = $urandom_range(99);
            if (pick < 1 && inits_left > 0)
            begin
                inits_left--;
                issue(REQ_INIT, ID_W'($urandom));
            end
            else if (pick < 50)
            begin
                issue(REQ_ALLOC, ID_W'($urandom));
            end
            else if (pick < 85 && held_ids.size() > 0)
            begin
                release_held();
            end
            else if (pick < 97)
            begin
                issue(REQ_RELEASE, ID_W'($urandom));
            end
            else
            begin
                issue(REQ_UNUSED, ID_W'($urandom));
            end
        end
    endtask

    initial
    begin
        logic [LFSR_W-1:0] phase_seed [3];
        int                phase_gap [3];
        phase_seed[0] = 16'hFFFF;
        phase_seed[1] = LFSR_W'($urandom_range(65534, 2));
        phase_seed[2] = 16'd1;
        phase_gap[0] = 11;
        phase_gap[1] = 61;
        phase_gap[2] = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = phase_gap[0];
        issue(REQ_ALLOC, 10'd0);
        issue(REQ_RELEASE, 10'h3FF);
        issue(REQ_ALLOC, 10'h3FF);
        issue(REQ_UNUSED, 10'h3FF);
        issue(REQ_UNUSED, 10'd0);
        issue(REQ_INIT, 10'h3FF);
        issue(REQ_ALLOC, 10'd0);
        issue(REQ_ALLOC, 10'h3FF);
        issue(REQ_RELEASE, 10'd0);
        issue(REQ_RELEASE, 10'h3FF);
        issue(REQ_ALLOC, 10'd0);
        issue(REQ_ALLOC, 10'd0);
        issue(REQ_ALLOC, 10'd0);
        issue(REQ_RELEASE, 10'd999);
        issue(REQ_RELEASE, 10'd100);
        issue(REQ_RELEASE, 10'd100);
        // zero seed must behave as seed 1
        write_seed(16'd0);
        issue(REQ_INIT, 10'd0);
        issue(REQ_ALLOC, 10'd0);
        issue(REQ_ALLOC, 10'd0);
        issue(REQ_RELEASE, 10'h3FF);
        issue(REQ_INIT, 10'd0);
        issue(REQ_ALLOC, 10'd0);

        for (int p = 0; p < 3; p++)
        begin
            write_seed(phase_seed[p]);
            gap_pct = phase_gap[p];
            issue(REQ_INIT, ID_W'($urandom));
            random_items(160);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/sia_pkg.sv
rtl/sia_pool_ram.sv
rtl/sia_stack_ram.sv
rtl/sia_mod_unit.sv
rtl/shuffled_id_allocator_top.sv
verif/testbench.sv
